FILE: sv/dtdt_pkg.sv
// ---------------------------------------------------------------------------
// dtdt_pkg: shared constants for the double to decimal text unit
// Character codes, the integer cap, default digit counts and the saturation limit.
// ---------------------------------------------------------------------------
package dtdt_pkg;
  localparam int FractionDigitsDefault = 6;
  localparam int IntegerDigitsDefault = 10;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharDot = 8'h2e;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [31:0] IntCap = 32'd2147483647;

  // saturation limit: min(10^digits - 1, 2^31 - 1)
  function automatic logic [31:0] sat_limit(input int digits);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < 10; k++) begin
      if (k < digits) p = p * 64'd10;
    end
    p = p - 64'd1;
    if (p > {32'd0, IntCap}) p = {32'd0, IntCap};
    return p[31:0];
  endfunction
endpackage

FILE: sv/double_to_decimal_text_unit.sv
// ---------------------------------------------------------------------------
// double_to_decimal_text_unit: binary64 to fixed point decimal text
// Unpacks a double, splits integer and fraction, then emits characters.
// ---------------------------------------------------------------------------
// An accepted item passes the stage 1, 2 and 3 registers, then loads into the emitter.
// Throughput: one character per cycle unless the receiver stalls; an item of n characters
//   (8..18 at the default) holds the emitter until its last character is taken, and the
//   front stages accept the next item meanwhile, so texts follow back to back with no gaps.
// The emitter derives one digit per cycle unless stalled (compare against multiples of a
//   power of ten, fraction times ten). Sync active-high reset clears valids.
module double_to_decimal_text_unit #(
  parameter int FRACTION_DIGITS = dtdt_pkg::FractionDigitsDefault,
  parameter int INTEGER_DIGITS = dtdt_pkg::IntegerDigitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value_bits[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_char[7:0]
  output logic        m_axis_tlast,   // last_char
  output logic        m_axis_tuser    // range_error
);
  localparam logic [31:0] Limit = dtdt_pkg::sat_limit(INTEGER_DIGITS);
  localparam int FdW = $clog2(FRACTION_DIGITS + 1);

  // power of ten for a digit place
  function automatic logic [31:0] pow10(input logic [3:0] idx);
    case (idx)
      4'd0: return 32'd1;
      4'd1: return 32'd10;
      4'd2: return 32'd100;
      4'd3: return 32'd1000;
      4'd4: return 32'd10000;
      4'd5: return 32'd100000;
      4'd6: return 32'd1000000;
      4'd7: return 32'd10000000;
      4'd8: return 32'd100000000;
      4'd9: return 32'd1000000000;
      default: return 32'd1;
    endcase
  endfunction

  // stage 1: unpack fields
  logic        v1;
  logic        neg1, nan1, zero1, big1;
  logic [52:0] m1;
  logic [10:0] sh1;        // right shift = 1075 - exponent, 1074 for subnormals

  // stage 2: integer part and fraction
  logic        v2;
  logic        neg2, zero2, err2;
  logic [63:0] ip2;
  logic [63:0] frac2;

  // stage 3: saturate, count integer digits
  logic        v3;
  logic        neg3, err3;
  logic [31:0] ip3;
  logic [63:0] frac3;

  // emitter
  typedef enum logic [1:0] {EM_SIGN, EM_INT, EM_DOT, EM_FRAC} em_t;
  logic        busy;
  em_t         phase;
  logic        err_e;
  logic [31:0] ip_e;
  logic [3:0]  pidx_e;      // digit position, power of ten index
  logic [63:0] frac_e;
  logic [FdW-1:0] fcnt;

  logic adv1, adv2, adv3, load, emit;
  assign emit = m_axis_tvalid & m_axis_tready;
  logic done_char;
  assign load = v3 & (!busy | (emit & done_char));
  assign adv3 = !v3 | load;
  assign adv2 = !v2 | adv3;
  assign adv1 = !v1 | adv2;
  assign s_axis_tready = adv1;

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_axis_tvalid;
    end
    if (adv1) begin
      neg1 <= s_axis_tdata[63];
      nan1 <= s_axis_tdata[62:52] == 11'h7ff;
      m1 <= {s_axis_tdata[62:52] != 11'd0, s_axis_tdata[51:0]};
      zero1 <= s_axis_tdata[62:0] == 63'd0;
      big1 <= s_axis_tdata[62:52] >= 11'd1075;
      sh1 <= (s_axis_tdata[62:52] == 11'd0) ? 11'd1074 : 11'd1075 - s_axis_tdata[62:52];
    end
  end

  // stage 2: shift mantissa into 64.64 fixed point
  logic [127:0] wide;
  always_comb begin
    wide = {75'd0, m1} << 64;
    if (sh1 >= 11'd128) wide = '0;
    else wide = wide >> sh1[6:0];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      neg2 <= neg1;
      zero2 <= zero1 & !nan1;
      err2 <= nan1 | big1;
      ip2 <= wide[127:64];
      frac2 <= wide[63:0];
    end
  end

  // stage 3: saturate and find leading digit place
  logic        err_s;
  assign err_s = err2 | (ip2 > {32'd0, Limit});
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      neg3 <= neg2 & !zero2;
      err3 <= err_s;
      ip3 <= err_s ? Limit : ip2[31:0];
      frac3 <= err_s ? 64'd0 : frac2;
    end
  end

  // leading digit place by parallel compares against fixed powers
  logic [3:0] pidx3;
  always_comb begin
    pidx3 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (ip3 >= pow10(4'(k))) pidx3 = 4'(k);
    end
  end

  // emitter datapath
  logic [3:0]  idig;
  logic [31:0] isub;
  logic [35:0] mult;
  logic [31:0] irem;
  logic [67:0] fmul;
  always_comb begin
    idig = 4'd0;
    isub = 32'd0;
    mult = 36'd0;
    for (int d = 1; d < 10; d++) begin
      mult = {4'd0, pow10(pidx_e)} * 36'(d);
      if ({4'd0, ip_e} >= mult) begin
        idig = 4'(d);
        isub = mult[31:0];
      end
    end
    irem = ip_e - isub;
    fmul = {4'd0, frac_e} * 68'd10;
    done_char = (phase == EM_FRAC) && (fcnt == FdW'(FRACTION_DIGITS - 1));
  end

  always_comb begin
    case (phase)
      EM_SIGN: m_axis_tdata = dtdt_pkg::CharMinus;
      EM_INT:  m_axis_tdata = dtdt_pkg::CharZero + {4'd0, idig};
      EM_DOT:  m_axis_tdata = dtdt_pkg::CharDot;
      EM_FRAC: m_axis_tdata = dtdt_pkg::CharZero + {4'd0, fmul[67:64]};
      default: m_axis_tdata = dtdt_pkg::CharZero;
    endcase
  end
  assign m_axis_tvalid = busy;
  assign m_axis_tlast = done_char;
  assign m_axis_tuser = err_e;

  // emitter sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= EM_SIGN;
    end else if (load) begin
      busy <= 1'b1;
      phase <= neg3 ? EM_SIGN : EM_INT;
      err_e <= err3;
      ip_e <= ip3;
      pidx_e <= pidx3;
      frac_e <= frac3;
      fcnt <= '0;
    end else if (emit) begin
      case (phase)
        EM_SIGN: phase <= EM_INT;
        EM_INT: begin
          ip_e <= irem;
          if (pidx_e == 4'd0) phase <= EM_DOT;
          else pidx_e <= pidx_e - 4'd1;
        end
        EM_DOT: phase <= EM_FRAC;
        EM_FRAC: begin
          frac_e <= fmul[63:0];
          fcnt <= fcnt + FdW'(1);
          if (done_char) busy <= 1'b0;
        end
        default: phase <= EM_SIGN;
      endcase
    end
  end

  // checks
  a_last_frac: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> phase == EM_FRAC) else $error("last off frac");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser && phase == EM_FRAC |-> m_axis_tdata == dtdt_pkg::CharZero)
    else $error("fraction on error");
  a_pow: assert property (@(posedge clk) disable iff (rst)
    busy && phase == EM_INT |-> pidx_e <= 4'd9) else $error("digit place lost");
endmodule

FILE: test/dtdt_checker.sv
// ---------------------------------------------------------------------------
// dtdt_checker: scoreboard for the double to decimal text unit
// Watches both streams, predicts the character text of every accepted
// double and compares each character, last flag and range flag in order.
// ---------------------------------------------------------------------------
module dtdt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value_bits[63:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // out_char[7:0]
  input  logic        m_axis_tlast,   // last_char
  input  logic        m_axis_tuser,   // range_error
  output int          fail_count,
  output int          pending_chars,
  output int          chars_seen,
  output int          range_texts
);
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_char_t;

  text_char_t char_queue[$];

  // saturation cap for ten integer digits
  localparam logic [31:0] IntLimit = 32'd2147483647;

  // build the text of one double and push its characters
  task automatic format_double(input logic [63:0] v);
    logic        neg, err, is_zero;
    logic [10:0] efld;
    logic [52:0] m;
    logic [63:0] ip, frac;
    logic [127:0] prod;
    int          ex, sh, nd, k;
    logic [7:0]  digs[10];
    text_char_t  text[$];
    neg = v[63];
    efld = v[62:52];
    err = 1'b0;
    is_zero = 1'b0;
    ip = '0;
    frac = '0;
    if (efld == 11'h7ff) begin
      err = 1'b1;
    end else begin
      if (efld == 0) begin
        m = {1'b0, v[51:0]};
        ex = -1074;
      end else begin
        m = {1'b1, v[51:0]};
        ex = int'(efld) - 1075;
      end
      is_zero = (m == 0);
      if (ex >= 0) begin
        err = 1'b1;
      end else begin
        sh = -ex;
        if (sh < 64) begin
          ip = 64'(m) >> sh;
          frac = (64'(m) & ((64'd1 << sh) - 64'd1)) << (64 - sh);
        end else if (sh < 128) begin
          frac = 64'(m) >> (sh - 64);
        end
        if (ip > 64'(IntLimit)) err = 1'b1;
      end
    end
    if (err) begin
      ip = 64'(IntLimit);
      frac = '0;
      range_texts++;
    end
    if (neg && !is_zero) text.push_back('{dtdt_pkg::CharMinus, 1'b0, err});
    nd = 0;
    do begin
      digs[nd] = dtdt_pkg::CharZero + 8'(ip % 10);
      ip = ip / 10;
      nd++;
    end while (ip != 0 && nd < 10);
    for (k = nd - 1; k >= 0; k--) text.push_back('{digs[k], 1'b0, err});
    text.push_back('{dtdt_pkg::CharDot, 1'b0, err});
    // fraction digits by repeated times ten
    for (k = 0; k < dtdt_pkg::FractionDigitsDefault; k++) begin
      prod = 128'(frac) * 128'd10;
      frac = prod[63:0];
      text.push_back('{dtdt_pkg::CharZero + prod[71:64], 1'b0, err});
    end
    text[text.size() - 1].last = 1'b1;
    foreach (text[i]) char_queue.push_back(text[i]);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      fail_count <= 0;
      chars_seen <= 0;
      range_texts = 0;
      char_queue.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) format_double(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen <= chars_seen + 1;
        if (char_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected char %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = char_queue.pop_front();
          if (want != {m_axis_tdata, m_axis_tlast, m_axis_tuser}) begin
            if (fail_count < 10)
              $display("mismatch: exp ch=%h last=%b err=%b got ch=%h last=%b err=%b",
                       want.ch, want.last, want.err, m_axis_tdata, m_axis_tlast,
                       m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_chars = char_queue.size();
endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: stimulus for the double to decimal text unit
// Drives directed and random doubles in bursts against a stalling receiver
// with one long hold-off; the checker scores every character.
// ---------------------------------------------------------------------------
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // value_bits[63:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_char[7:0]
  logic        m_axis_tlast;        // last_char
  logic        m_axis_tuser;        // range_error
  int          fail_count, pending_chars, chars_seen, range_texts;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          hold_off = 1'b0;

  localparam int CycleLimit = 200000;

  double_to_decimal_text_unit uut (.*);
  dtdt_checker checker_i (.*);

  always #4 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off once
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if (cycle_count % 300 < 100) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    wait (items_sent == 40);
    hold_off = 1'b1;
    repeat (150) @(negedge clk);
    hold_off = 1'b0;
  end

  // random double biased toward interesting exponents
  function automatic logic [63:0] pick_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: v[62:52] = 11'(1023 + $urandom_range(0, 32) - 10);
      3:       v[62:52] = 11'($urandom_range(990, 1023));
      4:       v[62:52] = 11'h7ff;
      5:       v[62:52] = 11'd0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_double(input logic [63:0] v);
    s_axis_tdata <= v;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  logic [63:0] directed[] = '{
    64'h0000000000000000, 64'h8000000000000000, 64'h3ff0000000000000,
    64'hbff0000000000000, 64'h3fe0000000000000, 64'h3fb999999999999a,
    64'h41dfffffffc00000, 64'h41e0000000000000, 64'hc1dfffffffffffff,
    64'h7ff0000000000000, 64'hfff0000000000000, 64'h7ff8000000000000,
    64'hfff8000000000001, 64'h0000000000000001, 64'h800fffffffffffff,
    64'h7fefffffffffffff, 64'h4330000000000000, 64'h432fffffffffffff,
    64'h3eb0c6f7a0b5ed8d, 64'h3eb0c6f7a0b5ed8c, 64'h3fefffffffffffff,
    64'h4023ffffffffffff, 64'h3c00000000000000, 64'hffffffffffffffff
  };

  initial begin
    int burst;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_double(directed[i]);
    // random part in bursts with gaps
    while (items_sent < 264) begin
      burst = $urandom_range(1, 12);
      repeat (burst) send_double(pick_double());
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending_chars == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d doubles, %0d with range error; %0d characters checked",
             items_sent, range_texts, chars_seen);
    if (fail_count == 0 && pending_chars == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
